@@ src/skt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes for the sorted key table
// Result status codes, read address selects, letter bounds and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    // read address select for the table memories
    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_PREV = 2'd2;

    localparam logic [7:0] LETTER_A = 8'h41;
    localparam logic [7:0] LETTER_Z = 8'h5A;

    typedef struct packed {
        logic       load;
        logic       scan_step;
        logic       scan_hit;
        logic       scan_end;
        logic       shift_step;
        logic       write_new;
        logic       res_load;
        logic [1:0] rd_sel;
        logic [1:0] res_status;
    } skt_cmd_t;

    typedef struct packed {
        logic key_ok;
        logic full;
        logic empty;
        logic eq;
        logic gt;
        logic last;
        logic at_pos;
        logic out_free;
    } skt_stat_t;

endpackage
`default_nettype wire

@@ src/skt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skt_datapath: table memories, scan and shift pointers, result register
// Holds the sorted key and payload memories, the working item, the entry
// count and the output register, and reports compare results to the
// controller.
// ----------------------------------------------------------------------------
module skt_datapath
    import skt_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int KEY_LETTERS  = 3,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [8*KEY_LETTERS-1:0]        s_key,
    input  wire logic [PAYLOAD_BITS-1:0]         s_payload,
    input  wire skt_cmd_t                        cmd,
    output skt_stat_t                            stat,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_status,
    output logic [$clog2(CAPACITY+1)-1:0]        m_position,
    output logic [$clog2(CAPACITY+1)-1:0]        m_count
);

    localparam int KW = 8 * KEY_LETTERS;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KW-1:0]           key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

    logic [KW-1:0]           key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [KW-1:0]           rd_key_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;
    logic [IW-1:0]           idx_reg;
    logic [CW-1:0]           pos_reg;
    logic [CW-1:0]           count_reg;
    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [CW-1:0]           m_position_reg;
    logic [CW-1:0]           m_count_reg;

    logic [IW-1:0]           idx_inc;
    logic [IW-1:0]           idx_dec;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           wr_addr;
    logic [KW-1:0]           wr_key;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    logic                    mem_we;
    logic                    key_ok;

    assign idx_inc = idx_reg + 1'b1;
    assign idx_dec = idx_reg - 1'b1;

    always_comb begin
        key_ok = 1'b1;
        for (int i = 0; i < KEY_LETTERS; i++) begin
            if (key_reg[8*i +: 8] < LETTER_A || key_reg[8*i +: 8] > LETTER_Z) begin
                key_ok = 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = idx_reg;
            RD_NEXT: rd_addr = idx_inc;
            RD_PREV: rd_addr = idx_dec;
            default: rd_addr = idx_reg;
        endcase
    end

    // shift moves the entry just read one slot up; otherwise place the new one
    always_comb begin
        mem_we  = cmd.shift_step | cmd.write_new;
        wr_addr = pos_reg[IW-1:0];
        wr_key  = key_reg;
        wr_pay  = payload_reg;
        if (cmd.shift_step) begin
            wr_addr = idx_inc;
            wr_key  = rd_key_reg;
            wr_pay  = rd_pay_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_pay_reg <= pay_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg     <= s_key;
            payload_reg <= s_payload;
        end
        if (cmd.res_load) begin
            m_status_reg   <= cmd.res_status;
            m_position_reg <= (cmd.res_status == ST_INSERTED) ? pos_reg : '0;
            m_count_reg    <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
                pos_reg <= '0;
            end else if (cmd.scan_hit) begin
                pos_reg <= CW'(idx_reg);
                idx_reg <= IW'(count_reg - 1'b1);
            end else if (cmd.scan_end) begin
                pos_reg <= count_reg;
            end else if (cmd.scan_step) begin
                idx_reg <= idx_inc;
            end else if (cmd.shift_step) begin
                idx_reg <= idx_dec;
            end
            if (cmd.write_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.key_ok   = key_ok;
        stat.full     = (count_reg == CW'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.eq       = (rd_key_reg == key_reg);
        stat.gt       = (rd_key_reg > key_reg);
        stat.last     = ((CW'(idx_reg) + 1'b1) == count_reg);
        stat.at_pos   = (CW'(idx_reg) == pos_reg);
        stat.out_free = ~m_valid_reg | m_ready;
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;
    assign m_count    = m_count_reg;

endmodule
`default_nettype wire

@@ src/skt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ctrl: sequencer for the sorted key table
// Steps one item through key check, ordered scan, upward shift, insert and
// result hand-off.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire skt_stat_t stat,
    output skt_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SH_START = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_WRITE    = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.rd_sel  = RD_IDX;
        cmd.res_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // entry zero is read here so the scan sees it next cycle
                cmd.rd_sel = RD_IDX;
                if (!stat.key_ok) begin
                    status_next = ST_INVALID;
                    state_next  = S_RESULT;
                end else if (stat.full) begin
                    status_next = ST_FULL;
                    state_next  = S_RESULT;
                end else if (stat.empty) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.rd_sel = RD_NEXT;
                if (stat.eq) begin
                    status_next = ST_DUPLICATE;
                    state_next  = S_RESULT;
                end else if (stat.gt) begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_SH_START;
                end else if (stat.last) begin
                    cmd.scan_end = 1'b1;
                    state_next   = S_WRITE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SH_START: begin
                cmd.rd_sel = RD_IDX;
                state_next = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.rd_sel     = RD_PREV;
                cmd.shift_step = 1'b1;
                if (stat.at_pos) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write_new = 1'b1;
                status_next   = ST_INSERTED;
                state_next    = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_INSERTED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire

@@ src/sorted_key_table_insert.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_insert: sorted key table with duplicate check
// Input transfer: s_key (letters, first letter in the top byte) and
// s_payload. Result transfer: m_status, m_position, m_count, one per item.
// Checks in order: any letter outside A..Z gives invalid key, a full table
// gives table full, a key already held gives duplicate; otherwise the entry
// goes in at its sorted position and larger entries move up one slot.
// One item at a time: s_ready is high only while the sequencer is idle.
// From input transfer to m_valid an item passes a load and a check step, an
// ordered scan of one memory read per cycle that stops at the first key not
// below the new one, a step to start the shift, the entries moved up one at
// a time (read and write of the table, which has separate read and write
// ports, overlap), an insert step and a result step. Invalid and full
// results go from the check straight to the result step.
// The result sits in an output register; while the receiver stalls, the next
// item is still accepted and worked, and only its result hand-off waits.
// Reset (aresetn low, synchronous) empties the table and clears m_valid.
// ----------------------------------------------------------------------------
module sorted_key_table_insert
    import skt_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int KEY_LETTERS  = 3,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [8*KEY_LETTERS-1:0]        s_key,
    input  wire logic [PAYLOAD_BITS-1:0]         s_payload,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_status,
    output logic [$clog2(CAPACITY+1)-1:0]        m_position,
    output logic [$clog2(CAPACITY+1)-1:0]        m_count
);

    skt_cmd_t  cmd;
    skt_stat_t stat;

    skt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    skt_datapath #(
        .CAPACITY     (CAPACITY),
        .KEY_LETTERS  (KEY_LETTERS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_key      (s_key),
        .s_payload  (s_payload),
        .cmd        (cmd),
        .stat       (stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_position (m_position),
        .m_count    (m_count)
    );

endmodule
`default_nettype wire
